// File: src/mexp_pkg.sv
package mexp_pkg;

   localparam int PosWidth = 16;
   localparam int MaxRes   = 4;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_STRING, MODE_NUMBER, MODE_IDENT, MODE_IDENT_WAIT, MODE_OPER, MODE_ERROR
   } mode_type;

   localparam logic [4:0] K_STRING = 5'd0;
   localparam logic [4:0] K_NUMBER = 5'd1;
   localparam logic [4:0] K_VARIABLE = 5'd2;
   localparam logic [4:0] K_FUNCTION = 5'd3;
   localparam logic [4:0] K_LPAREN = 5'd4;
   localparam logic [4:0] K_RPAREN = 5'd5;
   localparam logic [4:0] K_SCOPE_START = 5'd6;
   localparam logic [4:0] K_SCOPE_END = 5'd7;
   localparam logic [4:0] K_ARRAY_START = 5'd8;
   localparam logic [4:0] K_ARRAY_END = 5'd9;
   localparam logic [4:0] K_SEPARATOR = 5'd10;
   localparam logic [4:0] K_UPLUS = 5'd11;
   localparam logic [4:0] K_UMINUS = 5'd12;
   localparam logic [4:0] K_UNOT = 5'd13;
   localparam logic [4:0] K_PLUS = 5'd14;
   localparam logic [4:0] K_MINUS = 5'd15;
   localparam logic [4:0] K_MULTIPLY = 5'd16;
   localparam logic [4:0] K_DIVIDE = 5'd17;
   localparam logic [4:0] K_POWER = 5'd18;
   localparam logic [4:0] K_ASSIGN = 5'd19;
   localparam logic [4:0] K_LESS = 5'd20;
   localparam logic [4:0] K_GREATER = 5'd21;
   localparam logic [4:0] K_EQUAL = 5'd22;
   localparam logic [4:0] K_NOT_EQUAL = 5'd23;
   localparam logic [4:0] K_GREATER_EQ = 5'd24;
   localparam logic [4:0] K_LESS_EQ = 5'd25;
   localparam logic [4:0] K_BIT_AND = 5'd26;
   localparam logic [4:0] K_BIT_OR = 5'd27;
   localparam logic [4:0] K_LOG_AND = 5'd28;
   localparam logic [4:0] K_LOG_OR = 5'd29;
   localparam logic [4:0] K_NONE = 5'd30;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_STRING = 3'd1;
   localparam logic [2:0] ERR_NUMBER = 3'd2;
   localparam logic [2:0] ERR_MISPLACED = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN_OP = 3'd4;
   localparam logic [2:0] ERR_UNKNOWN_SYM = 3'd5;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   typedef struct packed {
      logic [4:0]          kind;
      logic [PosWidth-1:0] pos;
      logic [PosWidth-1:0] len;
      logic [2:0]          err;
   } res_type;

   typedef struct packed {
      res_type [MaxRes-1:0] res;
      logic [2:0]           cnt;
      logic                 eoe;
   } bundle_type;

   typedef struct packed {
      mode_type            mode;
      logic [PosWidth-1:0] tstart;
      logic [PosWidth-1:0] tlen;
      logic [PosWidth-1:0] cpos;
      logic [7:0]          last;
      logic [7:0]          opa;
      logic [7:0]          opb;
      logic [1:0]          opcnt;
   } lex_state_type;

   typedef struct packed {
      logic [2:0] err;
      logic [4:0] kind;
   } single_type;

   typedef struct packed {
      logic [2:0] err;
      logic [1:0] n;
      logic [4:0] k1;
      logic [4:0] k2;
      logic [1:0] len;
      logic [7:0] newlast;
   } flush_type;

   localparam lex_state_type STATE_RESET = '{
      mode: MODE_IDLE, tstart: '0, tlen: '0, cpos: '0,
      last: "(", opa: '0, opb: '0, opcnt: '0};

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == "," || c == ";" || c == CH_NEWLINE;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" || c == "!" ||
             c == "=" || c == "<" || c == ">" || c == "&" || c == "|";
   endfunction

   function automatic logic ident_start(input logic [7:0] c);
      return is_alpha(c) || c == "_";
   endfunction

   function automatic logic ident_body(input logic [7:0] c);
      return ident_start(c) || is_digit(c) || c == ".";
   endfunction

   function automatic logic lead_pos(input logic [7:0] c);
      return c == "(" || is_sep(c) || is_op(c);
   endfunction

   function automatic logic misplaced(input logic [7:0] c);
      return c == "(" || c == "{" || c == "[" || is_sep(c) || is_op(c);
   endfunction

   function automatic single_type single_op(input logic [7:0] c, input logic [7:0] prev);
      single_type r;
      r.err = ERR_NONE;
      r.kind = K_NONE;
      priority if (c == "-") r.kind = lead_pos(prev) ? K_UMINUS : K_MINUS;
      else if (c == "+") r.kind = lead_pos(prev) ? K_UPLUS : K_PLUS;
      else if (c == "!") r.kind = K_UNOT;
      else begin
         priority case (c)
            "*": r.kind = K_MULTIPLY;
            "/": r.kind = K_DIVIDE;
            "^": r.kind = K_POWER;
            "=": r.kind = K_ASSIGN;
            "<": r.kind = K_LESS;
            ">": r.kind = K_GREATER;
            "&": r.kind = K_BIT_AND;
            "|": r.kind = K_BIT_OR;
            default: r.err = ERR_UNKNOWN_OP;
         endcase
         if (r.err == ERR_NONE && misplaced(prev)) r.err = ERR_MISPLACED;
      end
      return r;
   endfunction

   function automatic logic [4:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] k;
      k = K_NONE;
      priority if (b == "=" && a == "=") k = K_EQUAL;
      else if (b == "=" && a == "!") k = K_NOT_EQUAL;
      else if (b == "=" && a == ">") k = K_GREATER_EQ;
      else if (b == "=" && a == "<") k = K_LESS_EQ;
      else if (a == "&" && b == "&") k = K_LOG_AND;
      else if (a == "|" && b == "|") k = K_LOG_OR;
      else k = K_NONE;
      return k;
   endfunction

   // resolve a pending operator run of one, two or more characters
   function automatic flush_type flush_run(input logic [7:0] a, input logic [7:0] b,
                                           input logic [1:0] cnt, input logic [7:0] prev);
      flush_type  r;
      single_type s1;
      single_type s2;
      logic [4:0] pk;
      r = '0;
      s1 = single_op(a, prev);
      s2 = single_op(b, a);
      pk = pair_kind(a, b);
      if (cnt == 2'd3) begin
         r.err = ERR_UNKNOWN_OP;
      end else if (cnt == 2'd1) begin
         r.err = s1.err;
         r.n = 2'd1;
         r.k1 = s1.kind;
         r.len = 2'd1;
         r.newlast = a;
      end else if (pk != K_NONE) begin
         r.err = misplaced(prev) ? ERR_MISPLACED : ERR_NONE;
         r.n = 2'd1;
         r.k1 = pk;
         r.len = 2'd2;
         r.newlast = b;
      end else begin
         r.err = (s1.err != ERR_NONE) ? s1.err : s2.err;
         r.n = 2'd2;
         r.k1 = s1.kind;
         r.k2 = s2.kind;
         r.len = 2'd1;
         r.newlast = b;
      end
      return r;
   endfunction

   // append a result; a fifth one is dropped
   function automatic bundle_type add_res(input bundle_type b, input logic [4:0] k,
                                          input logic [PosWidth-1:0] p,
                                          input logic [PosWidth-1:0] l, input logic [2:0] e);
      bundle_type r;
      r = b;
      if (b.cnt < 3'(MaxRes)) begin
         r.res[b.cnt[1:0]] = '{kind: k, pos: p, len: l, err: e};
         r.cnt = b.cnt + 3'd1;
      end
      return r;
   endfunction

endpackage

// File: src/mexp_lexer.sv
module mexp_lexer
   import mexp_pkg::*;
(
   input  lex_state_type cur_st,
   input  logic [7:0]    char_code,
   input  logic          end_of_input,
   output lex_state_type nxt_st,
   output bundle_type    bundle
);

   lex_state_type       st;
   bundle_type          b;
   flush_type           fl;
   logic                go;
   logic [PosWidth-1:0] pos;

   always_comb begin
      st = cur_st;
      b = '0;
      go = 1'b0;
      pos = cur_st.cpos;
      fl = flush_run(st.opa, st.opb, st.opcnt, st.last);

      unique case (cur_st.mode)
         MODE_STRING: begin
            if (char_code == "\"") begin
               b = add_res(b, K_STRING, st.tstart, st.tlen, ERR_NONE);
               st.last = "\"";
               st.mode = MODE_IDLE;
            end else if (st.tlen != '1) begin
               st.tlen = st.tlen + 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(char_code) || char_code == "." || char_code == "e" ||
                ((char_code == "-" || char_code == "+") && st.last == "e")) begin
               if (st.tlen != '1) st.tlen = st.tlen + 1'b1;
               st.last = char_code;
            end else if (ident_body(char_code)) begin
               b = add_res(b, K_NONE, st.tstart, '0, ERR_NUMBER);
               st.mode = MODE_ERROR;
            end else begin
               b = add_res(b, K_NUMBER, st.tstart, st.tlen, ERR_NONE);
               st.mode = MODE_IDLE;
               go = 1'b1;
            end
         end
         MODE_IDENT, MODE_IDENT_WAIT: begin
            if (cur_st.mode == MODE_IDENT && ident_body(char_code)) begin
               if (st.tlen != '1) st.tlen = st.tlen + 1'b1;
               st.last = char_code;
            end else if (char_code == " ") begin
               st.mode = MODE_IDENT_WAIT;
            end else begin
               b = add_res(b, (char_code == "(") ? K_FUNCTION : K_VARIABLE,
                           st.tstart, st.tlen, ERR_NONE);
               st.mode = MODE_IDLE;
               go = 1'b1;
            end
         end
         MODE_OPER: begin
            if (is_op(char_code)) begin
               if (st.opcnt == 2'd1) st.opb = char_code;
               if (st.opcnt != 2'd3) st.opcnt = st.opcnt + 2'd1;
            end else if (fl.err != ERR_NONE) begin
               b = add_res(b, K_NONE, st.tstart, '0, fl.err);
               st.mode = MODE_ERROR;
            end else begin
               b = add_res(b, fl.k1, st.tstart, PosWidth'(fl.len), ERR_NONE);
               if (fl.n == 2'd2) b = add_res(b, fl.k2, st.tstart, PosWidth'(fl.len), ERR_NONE);
               st.last = fl.newlast;
               st.mode = MODE_IDLE;
               go = 1'b1;
            end
         end
         MODE_IDLE: go = 1'b1;
         default: go = 1'b0;
      endcase

      if (go) begin
         priority if (char_code == "\"") begin
            st.mode = MODE_STRING;
            st.tstart = pos;
            st.tlen = '0;
         end else if (is_digit(char_code)) begin
            st.mode = MODE_NUMBER;
            st.tstart = pos;
            st.tlen = PosWidth'(1);
            st.last = char_code;
         end else if (ident_start(char_code)) begin
            st.mode = MODE_IDENT;
            st.tstart = pos;
            st.tlen = PosWidth'(1);
            st.last = char_code;
         end else if (is_op(char_code)) begin
            st.mode = MODE_OPER;
            st.tstart = pos;
            st.opa = char_code;
            st.opb = '0;
            st.opcnt = 2'd1;
         end else if (char_code == " ") begin
            st.mode = MODE_IDLE;
         end else begin
            st.last = char_code;
            priority case (char_code)
               "{": b = add_res(b, K_SCOPE_START, pos, '0, ERR_NONE);
               "}": begin
                  b = add_res(b, K_SCOPE_END, pos, '0, ERR_NONE);
                  b = add_res(b, K_SEPARATOR, pos, '0, ERR_NONE);
               end
               "[": b = add_res(b, K_ARRAY_START, pos, PosWidth'(1), ERR_NONE);
               "]": b = add_res(b, K_ARRAY_END, pos, PosWidth'(1), ERR_NONE);
               "(": b = add_res(b, K_LPAREN, pos, '0, ERR_NONE);
               ")": b = add_res(b, K_RPAREN, pos, '0, ERR_NONE);
               ",", ";", CH_NEWLINE: b = add_res(b, K_SEPARATOR, pos, '0, ERR_NONE);
               default: begin
                  st.last = cur_st.last;
                  b = add_res(b, K_NONE, pos, '0, ERR_UNKNOWN_SYM);
                  st.mode = MODE_ERROR;
               end
            endcase
         end
      end

      st.cpos = pos + 1'b1;

      if (end_of_input) begin
         fl = flush_run(st.opa, st.opb, st.opcnt, st.last);
         unique case (st.mode)
            MODE_STRING: b = add_res(b, K_NONE, st.tstart, '0, ERR_STRING);
            MODE_NUMBER: b = add_res(b, K_NUMBER, st.tstart, st.tlen, ERR_NONE);
            MODE_IDENT, MODE_IDENT_WAIT: b = add_res(b, K_VARIABLE, st.tstart, st.tlen, ERR_NONE);
            MODE_OPER: begin
               if (fl.err != ERR_NONE) begin
                  b = add_res(b, K_NONE, st.tstart, '0, fl.err);
               end else begin
                  b = add_res(b, fl.k1, st.tstart, PosWidth'(fl.len), ERR_NONE);
                  if (fl.n == 2'd2) begin
                     b = add_res(b, fl.k2, st.tstart, PosWidth'(fl.len), ERR_NONE);
                  end
               end
            end
            default: b.eoe = 1'b0;
         endcase
         if (b.cnt == 3'd0) b = add_res(b, K_NONE, pos, '0, ERR_NONE);
         b.eoe = 1'b1;
         st = STATE_RESET;
      end

      nxt_st = st;
      bundle = b;
   end

endmodule

// File: src/mexp_out_queue.sv
module mexp_out_queue
   import mexp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bundle_type          push_bundle,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_token_kind,
   output logic [PosWidth-1:0] rsp_start_pos,
   output logic [PosWidth-1:0] rsp_text_len,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_last_of_item,
   output logic                rsp_end_of_expression
);

   bundle_type [1:0] slot_ff;
   logic       [1:0] count_ff, count_in;
   logic             wptr_ff, rptr_ff;
   logic       [1:0] idx_ff, idx_in;
   bundle_type       head;
   res_type          cur;
   logic             last_beat, pop;

   assign head = slot_ff[rptr_ff];
   assign cur = head.res[idx_ff];
   assign last_beat = ({1'b0, idx_ff} == head.cnt - 3'd1);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop = rsp_valid && rsp_ready && last_beat;
   assign space = (count_ff != 2'd2);

   assign rsp_token_kind = cur.kind;
   assign rsp_start_pos = cur.pos;
   assign rsp_text_len = cur.len;
   assign rsp_error_code = cur.err;
   assign rsp_last_of_item = last_beat;
   assign rsp_end_of_expression = last_beat && head.eoe;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) idx_in = last_beat ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff <= idx_in;
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_bundle;
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2 || pop))
      else $error("bundle queue overflow");
   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (head.cnt != 3'd0 && {1'b0, idx_ff} < head.cnt))
      else $error("head bundle index out of range");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> push_bundle.cnt != 3'd0)
      else $error("empty bundle pushed");
   a_idx_rewind: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("beat index not rewound");
`endif

endmodule

// File: src/math_expression_tokenizer.sv
// Expression tokenizer: one character beat in, zero to four token beats out.
// Path: a character passes the input register, then the lexer step that pushes its
// tokens into a two-deep bundle queue.
// Throughput: one character per cycle while the queue has space; tokens drain one
// per cycle with rsp_ready high, so multi-token characters stall the input.
// Reset (synchronous, active high) returns the lexer to idle at position 0.
module math_expression_tokenizer
   import mexp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_code,
   input  logic                req_end_of_input,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_token_kind,
   output logic [PosWidth-1:0] rsp_start_pos,
   output logic [PosWidth-1:0] rsp_text_len,
   output logic [2:0]          rsp_error_code,
   output logic                rsp_last_of_item,
   output logic                rsp_end_of_expression
);

   // input register
   logic          in_valid_ff;
   logic [7:0]    in_char_ff;
   logic          in_eoi_ff;

   // lexer state, advanced once per processed character
   lex_state_type state_ff, state_in;
   bundle_type    bundle;
   logic          space, step, push;

   // a buffered character is stepped once the queue can take its tokens
   assign step = in_valid_ff && space;
   assign push = step && (bundle.cnt != 3'd0);
   assign req_ready = !in_valid_ff || step;

   mexp_lexer u_lexer (
      .cur_st       (state_ff),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .nxt_st       (state_in),
      .bundle       (bundle)
   );

   mexp_out_queue u_queue (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .push_bundle           (bundle),
      .space                 (space),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_token_kind        (rsp_token_kind),
      .rsp_start_pos         (rsp_start_pos),
      .rsp_text_len          (rsp_text_len),
      .rsp_error_code        (rsp_error_code),
      .rsp_last_of_item      (rsp_last_of_item),
      .rsp_end_of_expression (rsp_end_of_expression)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= STATE_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (step) state_ff <= state_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_eoi_ff <= req_end_of_input;
      end
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !space) |=> (in_valid_ff && $stable(in_char_ff)))
      else $error("buffered character lost while stalled");
   a_eoi_reset: assert property (@(posedge clock) disable iff (reset)
      (step && in_eoi_ff) |=> (state_ff.mode == MODE_IDLE && state_ff.cpos == '0))
      else $error("state not cleared after end of input");
   a_eoi_push: assert property (@(posedge clock) disable iff (reset)
      (step && in_eoi_ff) |-> push)
      else $error("end of input produced no token");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mexp_pkg::*;

   // one expected or observed token beat
   typedef struct packed {
      logic [4:0]          kind;
      logic [PosWidth-1:0] pos;
      logic [PosWidth-1:0] len;
      logic [2:0]          err;
      logic                last;
      logic                eoe;
   } token_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } char_type;

   localparam int CycleLimit = 400000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_char_code;
   logic                req_end_of_input;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [4:0]          rsp_token_kind;
   logic [PosWidth-1:0] rsp_start_pos;
   logic [PosWidth-1:0] rsp_text_len;
   logic [2:0]          rsp_error_code;
   logic                rsp_last_of_item;
   logic                rsp_end_of_expression;

   char_type  char_queue[$];
   token_type token_queue[$];
   int        failures;
   int        cycles;
   bit        hold_input;
   bit        no_idle;
   bit        req_taken;

   // predictor's private copy of the lexer state
   mode_type            lx_mode;
   logic [PosWidth-1:0] lx_start, lx_len, lx_cpos;
   logic [7:0]          lx_last, lx_opa, lx_opb;
   logic [1:0]          lx_opcnt;
   token_type           step_toks[$];

   math_expression_tokenizer dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- character classes ----------------
   function automatic bit c_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit c_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic bit c_sep(logic [7:0] c);
      return c == 8'h2c || c == 8'h3b || c == CH_NEWLINE;
   endfunction

   function automatic bit c_op(logic [7:0] c);
      case (c)
         "+", "-", "*", "/", "^", "!", "=", "<", ">", "&", "|": return 1;
         default: return 0;
      endcase
   endfunction

   function automatic bit c_body(logic [7:0] c);
      return c_alpha(c) || c_digit(c) || c == 8'h2e;
   endfunction

   function automatic bit c_unary_ctx(logic [7:0] c);
      return c == 8'h28 || c_sep(c) || c_op(c);
   endfunction

   function automatic bit c_bad_prev(logic [7:0] c);
      return c == 8'h28 || c == 8'h7b || c == 8'h5b || c_sep(c) || c_op(c);
   endfunction

   // ---------------- predictor ----------------
   function automatic void add_tok(logic [4:0] k, logic [PosWidth-1:0] p,
                                   logic [PosWidth-1:0] l, logic [2:0] e);
      token_type t;
      t = '{kind: k, pos: p, len: l, err: e, last: 1'b0, eoe: 1'b0};
      if (step_toks.size() < MaxRes) step_toks.insert(step_toks.size(), t);
   endfunction

   function automatic void lex_fail(logic [PosWidth-1:0] p, logic [2:0] e);
      add_tok(K_NONE, p, '0, e);
      lx_mode = MODE_ERROR;
   endfunction

   function automatic logic [PosWidth-1:0] sat_inc(logic [PosWidth-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // kind of a lone operator char, err 0 if fine
   function automatic void classify_op(input logic [7:0] c, input logic [7:0] prev,
                                       output logic [4:0] k, output logic [2:0] e);
      e = ERR_NONE;
      k = K_NONE;
      if (c == "-") k = c_unary_ctx(prev) ? K_UMINUS : K_MINUS;
      else if (c == "+") k = c_unary_ctx(prev) ? K_UPLUS : K_PLUS;
      else if (c == "!") k = K_UNOT;
      else begin
         case (c)
            "*": k = K_MULTIPLY;
            "/": k = K_DIVIDE;
            "^": k = K_POWER;
            "=": k = K_ASSIGN;
            "<": k = K_LESS;
            ">": k = K_GREATER;
            "&": k = K_BIT_AND;
            "|": k = K_BIT_OR;
            default: e = ERR_UNKNOWN_OP;
         endcase
         if (e == ERR_NONE && c_bad_prev(prev)) e = ERR_MISPLACED;
      end
   endfunction

   function automatic logic [4:0] two_char_kind(logic [7:0] a, logic [7:0] b);
      if (b == "=" && a == "=") return K_EQUAL;
      if (b == "=" && a == "!") return K_NOT_EQUAL;
      if (b == "=" && a == ">") return K_GREATER_EQ;
      if (b == "=" && a == "<") return K_LESS_EQ;
      if (a == "&" && b == "&") return K_LOG_AND;
      if (a == "|" && b == "|") return K_LOG_OR;
      return K_NONE;
   endfunction

   // resolve pending operator run; returns 0 on error
   function automatic bit resolve_ops();
      logic [4:0] k1, k2;
      logic [2:0] e;
      if (lx_opcnt == 2'd3) begin
         lex_fail(lx_start, ERR_UNKNOWN_OP);
         return 0;
      end
      if (lx_opcnt == 2'd1) begin
         classify_op(lx_opa, lx_last, k1, e);
         if (e != ERR_NONE) begin
            lex_fail(lx_start, e);
            return 0;
         end
         add_tok(k1, lx_start, PosWidth'(1), ERR_NONE);
         lx_last = lx_opa;
         return 1;
      end
      k1 = two_char_kind(lx_opa, lx_opb);
      if (k1 != K_NONE) begin
         if (c_bad_prev(lx_last)) begin
            lex_fail(lx_start, ERR_MISPLACED);
            return 0;
         end
         add_tok(k1, lx_start, PosWidth'(2), ERR_NONE);
      end else begin
         classify_op(lx_opa, lx_last, k1, e);
         if (e == ERR_NONE) classify_op(lx_opb, lx_opa, k2, e);
         if (e != ERR_NONE) begin
            lex_fail(lx_start, e);
            return 0;
         end
         add_tok(k1, lx_start, PosWidth'(1), ERR_NONE);
         add_tok(k2, lx_start, PosWidth'(1), ERR_NONE);
      end
      lx_last = lx_opb;
      return 1;
   endfunction

   task automatic lex_reset();
      lx_mode = MODE_IDLE;
      lx_start = '0;
      lx_len = '0;
      lx_cpos = '0;
      lx_last = "(";
      lx_opa = '0;
      lx_opb = '0;
      lx_opcnt = '0;
   endtask

   // a character seen in idle mode
   task automatic start_token(logic [7:0] c, logic [PosWidth-1:0] p);
      if (c == 8'h22) begin
         lx_mode = MODE_STRING; lx_start = p; lx_len = '0;
      end else if (c_digit(c)) begin
         lx_mode = MODE_NUMBER; lx_start = p; lx_len = PosWidth'(1); lx_last = c;
      end else if (c_alpha(c)) begin
         lx_mode = MODE_IDENT; lx_start = p; lx_len = PosWidth'(1); lx_last = c;
      end else if (c_op(c)) begin
         lx_mode = MODE_OPER; lx_start = p; lx_opa = c; lx_opb = '0; lx_opcnt = 2'd1;
      end else begin
         case (c)
            "{": add_tok(K_SCOPE_START, p, '0, ERR_NONE);
            "}": begin
               add_tok(K_SCOPE_END, p, '0, ERR_NONE);
               add_tok(K_SEPARATOR, p, '0, ERR_NONE);
            end
            "[": add_tok(K_ARRAY_START, p, PosWidth'(1), ERR_NONE);
            "]": add_tok(K_ARRAY_END, p, PosWidth'(1), ERR_NONE);
            "(": add_tok(K_LPAREN, p, '0, ERR_NONE);
            ")": add_tok(K_RPAREN, p, '0, ERR_NONE);
            ",", ";", CH_NEWLINE: add_tok(K_SEPARATOR, p, '0, ERR_NONE);
            " ": ;
            default: lex_fail(p, ERR_UNKNOWN_SYM);
         endcase
         if (c != " " && lx_mode != MODE_ERROR) lx_last = c;
      end
   endtask

   // one accepted character -> expected tokens appended to token_queue
   task automatic predict_tokens(char_type it);
      logic [7:0]          c;
      logic [PosWidth-1:0] p;
      bit                  go_idle;
      c = it.ch;
      p = lx_cpos;
      step_toks.delete();
      go_idle = 0;
      case (lx_mode)
         MODE_STRING:
            if (c == 8'h22) begin
               add_tok(K_STRING, lx_start, lx_len, ERR_NONE);
               lx_last = c;
               lx_mode = MODE_IDLE;
            end else lx_len = sat_inc(lx_len);
         MODE_NUMBER:
            if (c_digit(c) || c == "." || c == "e" ||
                ((c == "-" || c == "+") && lx_last == "e")) begin
               lx_len = sat_inc(lx_len);
               lx_last = c;
            end else if (c_body(c)) lex_fail(lx_start, ERR_NUMBER);
            else begin
               add_tok(K_NUMBER, lx_start, lx_len, ERR_NONE);
               go_idle = 1;
            end
         MODE_IDENT:
            if (c_body(c)) begin
               lx_len = sat_inc(lx_len);
               lx_last = c;
            end else if (c == " ") lx_mode = MODE_IDENT_WAIT;
            else begin
               add_tok(c == "(" ? K_FUNCTION : K_VARIABLE, lx_start, lx_len, ERR_NONE);
               go_idle = 1;
            end
         MODE_IDENT_WAIT:
            if (c != " ") begin
               add_tok(c == "(" ? K_FUNCTION : K_VARIABLE, lx_start, lx_len, ERR_NONE);
               go_idle = 1;
            end
         MODE_OPER:
            if (c_op(c)) begin
               if (lx_opcnt == 2'd1) lx_opb = c;
               if (lx_opcnt != 2'd3) lx_opcnt++;
            end else if (resolve_ops()) go_idle = 1;
         MODE_IDLE: go_idle = 1;
         default: ;
      endcase
      if (go_idle) begin
         lx_mode = MODE_IDLE;
         start_token(c, p);
      end
      lx_cpos = p + 1'b1;
      if (it.eoi) begin
         case (lx_mode)
            MODE_STRING: lex_fail(lx_start, ERR_STRING);
            MODE_NUMBER: add_tok(K_NUMBER, lx_start, lx_len, ERR_NONE);
            MODE_IDENT, MODE_IDENT_WAIT: add_tok(K_VARIABLE, lx_start, lx_len, ERR_NONE);
            MODE_OPER: void'(resolve_ops());
            default: ;
         endcase
         if (step_toks.size() == 0) add_tok(K_NONE, p, '0, ERR_NONE);
         step_toks[step_toks.size()-1].eoe = 1'b1;
         lex_reset();
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      foreach (step_toks[i]) token_queue.insert(token_queue.size(), step_toks[i]);
   endtask

   // ---------------- stimulus helpers ----------------
   task automatic add_text(string s, bit close_expr);
      char_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.ch = s[i];
         it.eoi = close_expr && (i == s.len() - 1);
         char_queue.insert(char_queue.size(), it);
      end
   endtask

   function automatic string pick_atom();
      string atoms[16] = '{"x", "foo_1", "sin(", "a.b", "12", "3.5e-2", "1e+7", "\"str\"",
                           "(", ")", "[", "]", "{", "}", ",", " "};
      return atoms[$urandom_range(0, 15)];
   endfunction

   function automatic string pick_op();
      string ops[22] = '{"+", "-", "*", "/", "^", "!", "=", "<", ">", "&", "|",
                         "==", "!=", ">=", "<=", "&&", "||", "+-", "*-", "<>", "+++", "-!"};
      return ops[$urandom_range(0, 21)];
   endfunction

   // ---------------- driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (char_queue.size() > 0 && !hold_input &&
                (no_idle || $urandom_range(0, 99) >= 22)) begin
               req_valid <= 1'b1;
               req_char_code <= char_queue[0].ch;
               req_end_of_input <= char_queue[0].eoi;
               void'(char_queue.pop_front());
            end else req_valid <= 1'b0;
         end
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= 22);
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_valid && req_ready) predict_tokens('{ch: req_char_code, eoi: req_end_of_input});
         if (rsp_valid && rsp_ready) begin
            token_type got, want;
            got = '{kind: rsp_token_kind, pos: rsp_start_pos, len: rsp_text_len,
                    err: rsp_error_code, last: rsp_last_of_item,
                    eoe: rsp_end_of_expression};
            if (token_queue.size() == 0) begin
               failures <= failures + 1;
               $display("%0t: unexpected token beat %p", $time, got);
            end else begin
               want = token_queue.pop_front();
               if (got != want) begin
                  failures <= failures + 1;
                  $display("%0t: token mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
         if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      int    n;
      string s;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_char_code = '0;
      req_end_of_input = 1'b0;
      req_taken = 1'b0;
      failures = 0;
      cycles = 0;
      hold_input = 0;
      no_idle = 0;
      lex_reset();
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: extremes, all kinds, each error class
      add_text("-x+sin(2)*3.5e-1/y^2", 1);
      add_text("a==b!=c>=d<=e&&f||g&h|i<j>k=!l", 1);
      add_text("{[ab],c;}\n\"q\" +-1", 1);
      add_text("12a", 1);
      add_text("(*", 1);
      add_text("1+++2", 1);
      add_text("\"open", 1);
      add_text("x", 0);
      char_queue.insert(char_queue.size(), '{ch: 8'hff, eoi: 1'b0});
      char_queue.insert(char_queue.size(), '{ch: 8'h00, eoi: 1'b1});
      add_text("f (", 1);
      add_text(" ", 1);
      add_text("9", 1);

      // drain fully before random part
      hold_input = 0;
      wait (char_queue.size() == 0);
      hold_input = 1;
      wait (token_queue.size() == 0 && !req_valid);
      repeat (4) @(posedge clock);
      hold_input = 0;

      for (int e = 0; e < 14; e++) begin
         n = $urandom_range(1, 6);
         s = "";
         if ($urandom_range(0, 9) < 8) begin
            // well-formed-ish expression
            for (int k = 0; k < n; k++) begin
               s = {s, pick_atom()};
               if (k < n - 1) s = {s, pick_op()};
            end
            add_text(s, 1);
         end else begin
            // byte noise
            for (int k = 0; k < n; k++)
               char_queue.insert(char_queue.size(), '{ch: 8'($urandom), eoi: k == n - 1});
         end
         if (e == 4) begin
            wait (char_queue.size() == 0);
            no_idle = 1;
         end
         if (e == 11) begin
            wait (char_queue.size() == 0);
            no_idle = 0;
         end
      end

      wait (char_queue.size() == 0);
      wait (token_queue.size() == 0 && !req_valid);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
